### hdl/key1bc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key1bc_pkg: shared types and constants of the key1 block cipher
// Table geometry, operation codes, the command group that the set-up
// sequencer sends to the cipher engine, and the byte swap used in key mixing.
// ----------------------------------------------------------------------------
package key1bc_pkg;

   localparam int unsigned RoundKeys = 18;
   localparam int unsigned SboxCount = 4;
   localparam int unsigned SboxWords = 256;

   typedef logic [31:0] word_type;
   typedef logic [10:0] index_type;

   // Last word of the key table, start of the first S-box, last even word
   // written by table regeneration.
   localparam index_type TableLast = 11'd1041;
   localparam index_type SboxBase  = 11'h012;
   localparam index_type RegenLast = 11'h410;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_SETUP   = 2'd1,
      FUNC_ENCRYPT = 2'd2,
      FUNC_DECRYPT = 2'd3
   } func_type;

   typedef struct packed {
      logic      start;
      logic      decrypt;
      logic      wr_en;
      index_type wr_idx;
      logic      mix_en;
   } eng_cmd_type;

   function automatic word_type swap_bytes(input word_type v);
      swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

### hdl/key1bc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key1bc_engine: working key table and iterative round engine
// Holds the 18 round keys in registers and the four S-boxes in memories,
// and runs the rounds one at a time, each a read phase and a mix phase, through one shared round unit.
// ----------------------------------------------------------------------------
module key1bc_engine
   import key1bc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  eng_cmd_type      cmd_i,
   input  word_type         first_i,
   input  word_type         second_i,
   input  word_type         wr_data_i,
   input  logic [2:0][31:0] kc_i,
   input  logic [1:0]       mod_i,
   output logic             done_o,
   output word_type         res_first_o,
   output word_type         res_second_o
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_READ = 3'b010,
      PH_MIX  = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        done_ff, done_in;
   logic        dec_ff, dec_in;
   logic [3:0]  n_ff, n_in;
   word_type    y_ff, y_in;
   word_type    z_ff, z_in;
   word_type    res_first_ff, res_first_in;
   word_type    res_second_ff, res_second_in;

   word_type    p_ff [RoundKeys];
   word_type    sbox_mem [SboxCount][SboxWords];
   word_type    sbox_q_ff [SboxCount];

   word_type    mix_val [RoundKeys];
   word_type    round_f;
   word_type    x_new;
   index_type   sbox_off;
   logic        sbox_we;
   logic [3:0]  n_next;

   function automatic logic [4:0] key_index(input logic dec, input logic [3:0] n);
      key_index = dec ? (5'd17 - {1'b0, n}) : {1'b0, n};
   endfunction

   // Keycode word for each round key: the index cycles with the modulus,
   // and a modulus of zero uses only the first word.
   for (genvar i = 0; i < RoundKeys; i++) begin : g_mix
      localparam int unsigned Sel2 = i % 2;
      localparam int unsigned Sel3 = i % 3;
      always_comb begin
         unique case (mod_i)
            2'd3:    mix_val[i] = kc_i[Sel3];
            2'd2:    mix_val[i] = kc_i[Sel2];
            default: mix_val[i] = kc_i[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RoundKeys; i++) begin
         if (cmd_i.mix_en) begin
            p_ff[i] <= p_ff[i] ^ swap_bytes(mix_val[i]);
         end else if (cmd_i.wr_en && cmd_i.wr_idx == 11'(i)) begin
            p_ff[i] <= wr_data_i;
         end
      end
   end

   assign sbox_off = cmd_i.wr_idx - SboxBase;
   assign sbox_we  = cmd_i.wr_en && (cmd_i.wr_idx >= SboxBase);

   // S-box b is addressed by byte b of z, most significant byte first.
   for (genvar b = 0; b < SboxCount; b++) begin : g_sbox
      always_ff @(posedge clock) begin
         if (sbox_we && sbox_off[9:8] == 2'(b)) begin
            sbox_mem[b][sbox_off[7:0]] <= wr_data_i;
         end
         sbox_q_ff[b] <= sbox_mem[b][z_ff[31 - 8 * b -: 8]];
      end
   end

   assign round_f = ((sbox_q_ff[0] + sbox_q_ff[1]) ^ sbox_q_ff[2]) + sbox_q_ff[3];
   assign x_new   = round_f ^ y_ff;
   assign n_next  = n_ff + 4'd1;

   always_comb begin
      phase_in      = phase_ff;
      done_in       = 1'b0;
      dec_in        = dec_ff;
      n_in          = n_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (cmd_i.start) begin
               dec_in   = cmd_i.decrypt;
               n_in     = 4'd0;
               y_in     = first_i;
               z_in     = p_ff[key_index(cmd_i.decrypt, 4'd0)] ^ second_i;
               phase_in = PH_READ;
            end
         end
         PH_READ: begin
            phase_in = PH_MIX;
         end
         PH_MIX: begin
            y_in = z_ff;
            if (n_ff == 4'd15) begin
               res_first_in  = x_new ^ p_ff[dec_ff ? 5'd1 : 5'd16];
               res_second_in = z_ff ^ p_ff[dec_ff ? 5'd0 : 5'd17];
               done_in       = 1'b1;
               phase_in      = PH_IDLE;
            end else begin
               z_in     = p_ff[key_index(dec_ff, n_next)] ^ x_new;
               n_in     = n_next;
               phase_in = PH_READ;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff        <= dec_in;
      n_ff          <= n_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
   end

   assign done_o       = done_ff;
   assign res_first_o  = res_first_ff;
   assign res_second_o = res_second_ff;

endmodule

### hdl/key1_block_cipher.sv
`timescale 1ns / 1ps
// Block beats: rsp_tvalid rises after the 16 engine rounds, through ST_BLOCK and ST_DONE into the output register.
// Write beats: the zero result is offered through ST_DONE once the output register is free.
// Key set-up: a table copy, then per key level two keycode encryptions, round key mixing and table regeneration.
// One beat at a time: a new beat is accepted only in ST_IDLE, after the last has gone to the output register.
// Synchronous active-high reset clears the sequencer and result valid and sets keycode_modulus to 2;
// key tables are undefined until written.
// ----------------------------------------------------------------------------
// key1_block_cipher: Blowfish-style 64-bit block cipher with a 1042-word key
// Holds the base key table, sequences key set-up and drives the round engine.
// ----------------------------------------------------------------------------
module key1_block_cipher
   import key1bc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // Input stream.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: table_index[10:0], table_value[42:11], word_lo[74:43],
   // word_hi[106:75], id_code[138:107], key_level[140:139], zero fill.
   input  logic [143:0] req_tdata,
   // tuser: func[1:0].
   input  logic [1:0]   req_tuser,
   // Result stream.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: out_lo[31:0], out_hi[63:32].
   output logic [63:0]  rsp_tdata,
   // Configuration: keycode_modulus.
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data
);

   // The sequencer walks through copy, keycode encryptions, round key
   // mixing and table regeneration; each encryption is handed to the engine.
   typedef enum logic [14:0] {
      ST_IDLE      = 15'b000000000000001,
      ST_COPY      = 15'b000000000000010,
      ST_COPY_END  = 15'b000000000000100,
      ST_APPLY     = 15'b000000000001000,
      ST_KC12      = 15'b000000000010000,
      ST_KC12_WAIT = 15'b000000000100000,
      ST_KC01      = 15'b000000001000000,
      ST_KC01_WAIT = 15'b000000010000000,
      ST_MIX       = 15'b000000100000000,
      ST_RG_START  = 15'b000001000000000,
      ST_RG_WAIT   = 15'b000010000000000,
      ST_RG_WR0    = 15'b000100000000000,
      ST_RG_WR1    = 15'b001000000000000,
      ST_BLOCK     = 15'b010000000000000,
      ST_DONE      = 15'b100000000000000
   } state_type;

   localparam int unsigned TableWords = 1042;

   // Unpacked input beat.
   func_type   in_func;
   index_type  in_index;
   word_type   in_value;
   word_type   in_lo;
   word_type   in_hi;
   word_type   in_id;
   logic [1:0] in_level;
   logic       req_accept;

   state_type        state_ff, state_in;
   logic [1:0]       mod_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_lo_ff, rsp_lo_in;
   word_type         rsp_hi_ff, rsp_hi_in;
   logic             is_block_ff, is_block_in;
   logic [2:0][31:0] kc_ff, kc_in;
   logic [1:0]       level_ff, level_in;
   logic [1:0]       app_ff, app_in;
   index_type        copy_idx_ff, copy_idx_in;
   logic             copy_wr_ff, copy_wr_in;
   index_type        copy_wr_idx_ff, copy_wr_idx_in;
   index_type        rg_idx_ff, rg_idx_in;
   word_type         a_ff, a_in;
   word_type         b_ff, b_in;

   // Base key table, written by write beats and swept by the copy.
   word_type   base_mem [TableWords];
   word_type   base_q_ff;
   logic       base_we;

   eng_cmd_type eng_cmd;
   word_type    eng_first;
   word_type    eng_second;
   word_type    eng_wr_data;
   logic        eng_done;
   word_type    eng_res_first;
   word_type    eng_res_second;

   assign in_func  = func_type'(req_tuser[1:0]);
   assign in_index = req_tdata[10:0];
   assign in_value = req_tdata[42:11];
   assign in_lo    = req_tdata[74:43];
   assign in_hi    = req_tdata[106:75];
   assign in_id    = req_tdata[138:107];
   assign in_level = req_tdata[140:139];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // A write beyond the last table word is dropped.
   assign base_we = req_accept && (in_func == FUNC_WRITE) && (in_index <= TableLast);

   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[in_index] <= in_value;
      end
      base_q_ff <= base_mem[copy_idx_ff];
   end

   // Commands and operands for the engine, by sequencer state.
   always_comb begin
      eng_cmd     = '0;
      eng_first   = '0;
      eng_second  = '0;
      eng_wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (in_func == FUNC_ENCRYPT || in_func == FUNC_DECRYPT)) begin
               eng_cmd.start   = 1'b1;
               eng_cmd.decrypt = (in_func == FUNC_DECRYPT);
               eng_first       = in_lo;
               eng_second      = in_hi;
            end
         end
         ST_COPY, ST_COPY_END: begin
            // The copy write follows its table read in the next cycle, through the registered read data.
            eng_cmd.wr_en  = copy_wr_ff;
            eng_cmd.wr_idx = copy_wr_idx_ff;
            eng_wr_data    = base_q_ff;
         end
         ST_KC12: begin
            eng_cmd.start = 1'b1;
            eng_first     = kc_ff[1];
            eng_second    = kc_ff[2];
         end
         ST_KC01: begin
            eng_cmd.start = 1'b1;
            eng_first     = kc_ff[0];
            eng_second    = kc_ff[1];
         end
         ST_MIX: begin
            eng_cmd.mix_en = 1'b1;
         end
         ST_RG_START: begin
            eng_cmd.start = 1'b1;
            eng_first     = a_ff;
            eng_second    = b_ff;
         end
         ST_RG_WR0: begin
            eng_cmd.wr_en  = 1'b1;
            eng_cmd.wr_idx = rg_idx_ff;
            eng_wr_data    = b_ff;
         end
         ST_RG_WR1: begin
            eng_cmd.wr_en  = 1'b1;
            eng_cmd.wr_idx = {rg_idx_ff[10:1], 1'b1};
            eng_wr_data    = a_ff;
         end
         default: ;
      endcase
   end

   key1bc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd_i        (eng_cmd),
      .first_i      (eng_first),
      .second_i     (eng_second),
      .wr_data_i    (eng_wr_data),
      .kc_i         (kc_ff),
      .mod_i        (mod_ff),
      .done_o       (eng_done),
      .res_first_o  (eng_res_first),
      .res_second_o (eng_res_second)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_lo_in      = rsp_lo_ff;
      rsp_hi_in      = rsp_hi_ff;
      is_block_in    = is_block_ff;
      kc_in          = kc_ff;
      level_in       = level_ff;
      app_in         = app_ff;
      copy_idx_in    = copy_idx_ff;
      copy_wr_in     = 1'b0;
      copy_wr_idx_in = copy_wr_idx_ff;
      rg_idx_in      = rg_idx_ff;
      a_in           = a_ff;
      b_in           = b_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (in_func)
                  FUNC_WRITE: begin
                     is_block_in = 1'b0;
                     state_in    = ST_DONE;
                  end
                  FUNC_SETUP: begin
                     // Keycode words 0, 1 and 2 are id, id >> 1 and id << 1.
                     kc_in       = {in_id << 1, in_id >> 1, in_id};
                     level_in    = in_level;
                     app_in      = 2'd1;
                     copy_idx_in = '0;
                     is_block_in = 1'b0;
                     state_in    = ST_COPY;
                  end
                  FUNC_ENCRYPT, FUNC_DECRYPT: begin
                     is_block_in = 1'b1;
                     state_in    = ST_BLOCK;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_COPY: begin
            copy_wr_in     = 1'b1;
            copy_wr_idx_in = copy_idx_ff;
            if (copy_idx_ff == TableLast) begin
               state_in = ST_COPY_END;
            end else begin
               copy_idx_in = copy_idx_ff + 11'd1;
            end
         end
         ST_COPY_END: begin
            state_in = (level_ff == 2'd0) ? ST_DONE : ST_APPLY;
         end
         ST_APPLY: begin
            // The third level shifts keycode words 1 and 2 before it starts.
            if (app_ff == 2'd3) begin
               kc_in[1] = kc_ff[1] << 1;
               kc_in[2] = kc_ff[2] >> 1;
            end
            state_in = ST_KC12;
         end
         ST_KC12: state_in = ST_KC12_WAIT;
         ST_KC12_WAIT: begin
            if (eng_done) begin
               kc_in[1] = eng_res_first;
               kc_in[2] = eng_res_second;
               state_in = ST_KC01;
            end
         end
         ST_KC01: state_in = ST_KC01_WAIT;
         ST_KC01_WAIT: begin
            if (eng_done) begin
               kc_in[0] = eng_res_first;
               kc_in[1] = eng_res_second;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            a_in      = '0;
            b_in      = '0;
            rg_idx_in = '0;
            state_in  = ST_RG_START;
         end
         ST_RG_START: state_in = ST_RG_WAIT;
         ST_RG_WAIT: begin
            if (eng_done) begin
               a_in     = eng_res_first;
               b_in     = eng_res_second;
               state_in = ST_RG_WR0;
            end
         end
         ST_RG_WR0: state_in = ST_RG_WR1;
         ST_RG_WR1: begin
            if (rg_idx_ff == RegenLast) begin
               if (app_ff == level_ff) begin
                  state_in = ST_DONE;
               end else begin
                  app_in   = app_ff + 2'd1;
                  state_in = ST_APPLY;
               end
            end else begin
               rg_idx_in = rg_idx_ff + 11'd2;
               state_in  = ST_RG_START;
            end
         end
         ST_BLOCK: begin
            if (eng_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the output register once the previous beat has left.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_lo_in    = is_block_ff ? eng_res_first : '0;
               rsp_hi_in    = is_block_ff ? eng_res_second : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         copy_wr_ff   <= 1'b0;
         mod_ff       <= 2'd2;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         copy_wr_ff   <= copy_wr_in;
         if (csr_wr_en) begin
            mod_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_lo_ff      <= rsp_lo_in;
      rsp_hi_ff      <= rsp_hi_in;
      is_block_ff    <= is_block_in;
      kc_ff          <= kc_in;
      level_ff       <= level_in;
      app_ff         <= app_in;
      copy_idx_ff    <= copy_idx_in;
      copy_wr_idx_ff <= copy_wr_idx_in;
      rg_idx_ff      <= rg_idx_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hi_ff, rsp_lo_ff};

endmodule
